// ----- rtl/mandelbrot_escape_time_assert.svh -----
// assertion macros for the mandelbrot escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MET_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MET_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/met_pkg.sv -----
// shared constants, types and helpers of the mandelbrot escape-time block
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  // picture geometry and number format
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 40;
  localparam int FRAC_BITS = 27;

  // field widths
  localparam int COL_W = 7;
  localparam int ROW_W = 6;
  localparam int CNT_W = 12;
  localparam int Z_W   = 32;
  localparam int P_W   = 2 * Z_W;
  localparam int D_W   = 12;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(1000);

  // 4/N in q4.27, rounded to nearest
  localparam int STEP_RE = ((1 << 29) + COLUMNS / 2) / COLUMNS;
  localparam int STEP_IM = ((1 << 29) + ROWS / 2) / ROWS;

  // escape bound |z|^2 > 4 at full product scale
  localparam logic [P_W:0] ESC_LIMIT = (P_W + 1)'(4) << (2 * FRAC_BITS);

  localparam logic signed [P_W-1:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [P_W-1:0] Q_MIN = -64'sd2147483648;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_DONE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_FINISH
  } met_state_t;

  // finished pixel handed from the core to the output register
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    logic             in_set;
  } met_result_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [Z_W-1:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[Z_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/met_ifs.sv -----
// pixel and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface met_pix_if import met_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface met_res_if import met_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] iteration_count;
  logic             in_set;

  modport source (output valid, iteration_count, in_set, input ready);
  modport sink   (input valid, iteration_count, in_set, output ready);
endinterface

`default_nettype wire

// ----- rtl/met_mul.sv -----
// shared signed 32x32 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module met_mul import met_pkg::*; (
  input  logic                  clk,
  input  logic signed [Z_W-1:0] a,
  input  logic signed [Z_W-1:0] b,
  output logic signed [P_W-1:0] prod
);

  // full-width product, one per cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ----- rtl/met_core.sv -----
// sequencer and datapath around the shared multiplier
`timescale 1ns / 1ps
`default_nettype none

module met_core import met_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [COL_W-1:0] column,
  input  logic [ROW_W-1:0] row,
  input  logic [CNT_W-1:0] max_iterations,
  input  logic             res_free,
  output logic             idle,
  output met_result_t      result
);

  met_state_t state, state_next;

  logic [COL_W-1:0]      col_q;
  logic [ROW_W-1:0]      row_q;
  logic signed [Z_W-1:0] cr, ci, zr, zi;
  logic signed [P_W-1:0] rr, diff;
  logic [CNT_W-1:0]      it;
  logic                  in_set_q;
  logic                  res_done;

  logic signed [Z_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0] prod;
  logic signed [D_W-1:0] d_re, d_im;
  logic [P_W:0]          esc_sum;
  logic                  escape;
  logic signed [Z_W-1:0] c_map, re_new, im_new;

  met_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // pixel offsets in half steps: 2*index - N
  assign d_re = signed'(D_W'({col_q, 1'b0})) - D_W'(COLUMNS);
  assign d_im = signed'(D_W'({row_q, 1'b0})) - D_W'(ROWS);

  // escape test and component updates
  assign esc_sum = (P_W + 1)'($unsigned(rr)) + (P_W + 1)'($unsigned(prod));
  assign escape  = esc_sum > ESC_LIMIT;
  assign c_map   = sat32(prod >>> 1);
  assign re_new  = sat32((diff >>> FRAC_BITS) + P_W'(cr));
  assign im_new  = sat32((prod >>> (FRAC_BITS - 1)) + P_W'(ci));

  // multiplier operand select
  always_comb begin
    unique case (state)
      ST_MAP_RE: begin
        mul_a = Z_W'(d_re);
        mul_b = Z_W'(STEP_RE);
      end
      ST_MAP_IM: begin
        mul_a = Z_W'(d_im);
        mul_b = Z_W'(STEP_IM);
      end
      ST_MUL_RR: begin
        mul_a = zr;
        mul_b = zr;
      end
      ST_MUL_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handoff
  always_comb begin
    state_next = state;
    res_done   = 1'b0;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_MAP_RE;
      ST_MAP_RE:   state_next = ST_MAP_IM;
      ST_MAP_IM:   state_next = ST_MAP_DONE;
      ST_MAP_DONE: state_next = ST_MUL_RR;
      ST_MUL_RR:   state_next = (it == max_iterations) ? ST_FINISH : ST_MUL_II;
      ST_MUL_II:   state_next = ST_MUL_RI;
      ST_MUL_RI:   state_next = escape ? ST_FINISH : ST_UPDATE;
      ST_UPDATE:   state_next = ST_MUL_RR;
      ST_FINISH: begin
        if (res_free) begin
          res_done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  assign idle          = (state == ST_IDLE);
  assign result.done   = res_done;
  assign result.count  = it;
  assign result.in_set = in_set_q;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          col_q <= column;
          row_q <= row;
        end
      end
      ST_MAP_IM: begin
        cr <= c_map;
        zr <= c_map;
      end
      ST_MAP_DONE: begin
        ci <= c_map;
        zi <= c_map;
        it <= '0;
      end
      ST_MUL_RR: begin
        if (it == max_iterations) in_set_q <= 1'b1;
      end
      ST_MUL_II: begin
        rr <= prod;
      end
      ST_MUL_RI: begin
        in_set_q <= 1'b0;
        diff     <= rr - prod;
      end
      ST_UPDATE: begin
        zr <= re_new;
        zi <= im_new;
        it <= it + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time unit: takes one pixel (column, row), maps it to c in
// q4.27, starts z at c and iterates z = z^2 + c until |z|^2 > 4 or the
// max_iterations limit, then returns the count and an in-set flag. All
// products go through one shared 32x32 multiplier, and an iteration needs
// three of them (zr*zr, zi*zi, zr*zi), issued in the states ST_MUL_RR,
// ST_MUL_II and ST_MUL_RI before ST_UPDATE writes the new z. The reset limit
// is 1000. One pixel is in work at a time; the next may be taken while the
// last result still waits in the output register. max_iterations is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while the
// unit is idle, as the unit itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time import met_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  met_pix_if.sink          pix,
  met_res_if.source        res
);

  logic [CNT_W-1:0] max_iterations;
  logic             core_idle;
  logic             res_free;
  met_result_t      result;
  logic             out_valid;
  logic [CNT_W-1:0] out_count;
  logic             out_in_set;

  // iteration limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_wr_en) begin
      max_iterations <= cfg_wr_data;
    end
  end

  // no transaction in while in reset
  assign pix.ready = core_idle && !rst;
  assign res_free  = !out_valid || res.ready;

  met_core u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (pix.valid && pix.ready),
    .column         (pix.column),
    .row            (pix.row),
    .max_iterations (max_iterations),
    .res_free       (res_free),
    .idle           (core_idle),
    .result         (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.done) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.done) begin
      out_count  <= result.count;
      out_in_set <= result.in_set;
    end
  end

  assign res.valid           = out_valid;
  assign res.iteration_count = out_count;
  assign res.in_set          = out_in_set;

endmodule

`default_nettype wire

// ----- rtl/met_checker.sv -----
// port-level checks for the mandelbrot escape-time unit and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "mandelbrot_escape_time_assert.svh"

module met_checker import met_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_wr_en,
  input logic [CNT_W-1:0] cfg_wr_data,
  input logic             pix_valid,
  input logic             pix_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [CNT_W-1:0] iteration_count,
  input logic             in_set
);

  logic [CNT_W-1:0] limit_q;

  // mirror of the iteration limit seen on the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= MAX_ITER_RESET;
    end else if (cfg_wr_en) begin
      limit_q <= cfg_wr_data;
    end
  end

  // one pixel in work: busy right after a transaction in
  `MET_NEXT(a_busy_after_accept, pix_valid && pix_ready, !pix_ready, "ready after accept")

  // a stalled result holds
  `MET_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(iteration_count) && $stable(in_set), "result changed while stalled")

  // in-set flag matches the count reaching the limit
  `MET_IMPLY(a_in_set_flag, res_valid, in_set == (iteration_count == limit_q), "in_set mismatch")

  // count never passes the limit
  `MET_IMPLY(a_count_bound, res_valid, iteration_count <= limit_q, "count above limit")

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_wr_en       (cfg_wr_en),
  .cfg_wr_data     (cfg_wr_data),
  .pix_valid       (pix.valid),
  .pix_ready       (pix.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .iteration_count (res.iteration_count),
  .in_set          (res.in_set)
);

`default_nettype wire
